@@ sv/bwa_pkg.sv @@
// Shared types, codes and the quarter-wave cosine table for the block window applier.
`default_nettype none
package bwa_pkg;

  localparam int COS_DEPTH = 256;
  localparam int COS_BITS  = 8;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  localparam logic REG_WINDOW_TYPE  = 1'b0;
  localparam logic REG_BLOCK_LENGTH = 1'b1;

  localparam int CFG_DATA_WIDTH = 13;

  // Window codes
  localparam logic [1:0] WIN_RECT     = 2'd0;
  localparam logic [1:0] WIN_HANN     = 2'd1;
  localparam logic [1:0] WIN_HAMMING  = 2'd2;
  localparam logic [1:0] WIN_BLACKMAN = 2'd3;

  // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT for y below 2^22
  localparam int DIV25_SHIFT = 29;
  localparam logic [24:0] DIV25_MUL = 25'd21474837;

  typedef logic [30:0] rom_t [0:COS_DEPTH];

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIV,
    B_LOOK,
    B_INTERP,
    B_COMB,
    B_NUM,
    B_SCALE,
    B_MUL,
    B_WRITE
  } back_state_t;

  // Restoring long division, used only while the table is built
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rm;
    q = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[62:0], num[b]};
      if (rm >= den) begin
        rm = rm - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q1.30 cos over a quarter turn, truncated Taylor series
  function automatic rom_t build_rom();
    rom_t t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    bit stop;
    for (int k = 0; k <= COS_DEPTH; k++) begin
      x = (HALF_PI_Q30 * longint'(k)) >> COS_BITS;
      x2 = (x * x) >> 30;
      term = Q30_ONE;
      sum = longint'(Q30_ONE);
      stop = 1'b0;
      for (int n = 0; n < 12; n++) begin
        if (!stop) begin
          term = (term * x2) >> 30;
          term = udiv64(term, longint'((2 * n + 1) * (2 * n + 2)));
          if (term == 0) begin
            stop = 1'b1;
          end else if ((n & 1) == 0) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      t[k] = 31'(sum);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ sv/bwa_queue.sv @@
// Small register queue between the front and back parts.
`default_nettype none
module bwa_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/bwa_front.sv @@
// Front part: configuration registers, block position tracking and queue entry build.
`default_nettype none
module bwa_front #(
  parameter int MAX_BLOCK    = 4096,
  parameter int SAMPLE_WIDTH = 16,
  parameter int POS_WIDTH    = 12
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_we,
  input  wire logic                                     cfg_index,
  input  wire logic [bwa_pkg::CFG_DATA_WIDTH-1:0]       cfg_data,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]           sample,
  output logic                                          q_valid,
  input  wire logic                                     q_ready,
  output logic [3+2*POS_WIDTH+SAMPLE_WIDTH-1:0]         q_data
);
  localparam int NW = POS_WIDTH + 1;
  localparam int LW = (NW > bwa_pkg::CFG_DATA_WIDTH) ? NW : bwa_pkg::CFG_DATA_WIDTH;

  logic [1:0]                          win_sel;
  logic [bwa_pkg::CFG_DATA_WIDTH-1:0]  block_length;
  logic [POS_WIDTH-1:0]                position_index;
  logic [POS_WIDTH-1:0]                position_index_next;
  logic [LW-1:0]                       blk_n;
  logic [POS_WIDTH-1:0]                divisor;
  logic [POS_WIDTH-1:0]                pos_eff;
  logic                                last;
  logic                                take;

  always_comb begin
    if (block_length == '0 || LW'(block_length) > LW'(MAX_BLOCK)) begin
      blk_n = LW'(MAX_BLOCK);
    end else begin
      blk_n = LW'(block_length);
    end
    divisor = POS_WIDTH'(blk_n - 1'b1);
    // restart when the block was shortened under the current position
    pos_eff = (LW'(position_index) >= blk_n) ? '0 : position_index;
    last = (pos_eff == divisor);
    position_index_next = last ? '0 : pos_eff + 1'b1;
  end

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign take     = in_valid && q_ready;
  assign q_data   = {win_sel, last, divisor, pos_eff, sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sel        <= '0;
      block_length   <= '0;
      position_index <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bwa_pkg::REG_WINDOW_TYPE:  win_sel <= cfg_data[1:0];
          bwa_pkg::REG_BLOCK_LENGTH: block_length <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        position_index <= position_index_next;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/bwa_back.sv @@
// Back part: phase divider, shared cosine unit, coefficient and product, output register.
`default_nettype none
module bwa_back #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int POS_WIDTH    = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 q_valid,
  output logic                                      q_ready,
  input  wire logic [3+2*POS_WIDTH+SAMPLE_WIDTH-1:0] q_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]            windowed_sample,
  output logic                                      last_in_block
);
  localparam bwa_pkg::rom_t ROM = bwa_pkg::build_rom();
  localparam int PW = POS_WIDTH;
  localparam int SW = SAMPLE_WIDTH;
  localparam int PRW = SW + 19;

  bwa_pkg::back_state_t state;
  bwa_pkg::back_state_t state_next;

  // latched item
  logic [1:0]            wtype;
  logic                  last;
  logic [PW-1:0]         divisor;
  logic signed [SW-1:0]  smp;

  // divider
  logic [PW-1:0]         rem;
  logic [31:0]           quo;
  logic [4:0]            div_cnt;
  logic [PW:0]           rem_sh;
  logic                  rem_ge;

  // cosine unit
  logic                  pass;
  logic [31:0]           ph;
  logic [30:0]           r;
  logic [7:0]            idx;
  logic [30:0]           rom_a;
  logic [30:0]           rom_b;
  logic [30:0]           a_q;
  logic [30:0]           diff_q;
  logic                  down_q;
  logic                  neg_q;
  logic [29:0]           frac_q;
  logic [60:0]           interp;
  logic [30:0]           delta_q;
  logic [30:0]           mag;
  logic signed [31:0]    c1;
  logic signed [31:0]    c2;
  logic signed [31:0]    c_new;

  // coefficient and product
  logic signed [37:0]    num;
  logic [37:0]           num_r;
  logic [21:0]           y_q;
  logic [46:0]           scaled;
  logic [17:0]           coef_q;
  logic signed [PRW-1:0] prod_q;
  logic signed [PRW:0]   rounded;
  logic signed [PRW:0]   res;
  logic                  load_out;

  localparam logic signed [PRW:0] SMAX = (PRW + 1)'(2 ** (SW - 1) - 1);
  localparam logic signed [PRW:0] SMIN = -SMAX - 1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bwa_pkg::B_IDLE:   if (q_valid) state_next = bwa_pkg::B_DIV;
      bwa_pkg::B_DIV:    if (divisor == '0 || div_cnt == 5'd31) state_next = bwa_pkg::B_LOOK;
      bwa_pkg::B_LOOK:   state_next = bwa_pkg::B_INTERP;
      bwa_pkg::B_INTERP: state_next = bwa_pkg::B_COMB;
      bwa_pkg::B_COMB:   state_next = pass ? bwa_pkg::B_NUM : bwa_pkg::B_LOOK;
      bwa_pkg::B_NUM:    state_next = bwa_pkg::B_SCALE;
      bwa_pkg::B_SCALE:  state_next = bwa_pkg::B_MUL;
      bwa_pkg::B_MUL:    state_next = bwa_pkg::B_WRITE;
      bwa_pkg::B_WRITE:  if (load_out) state_next = bwa_pkg::B_IDLE;
      default:           state_next = bwa_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready  = (state == bwa_pkg::B_IDLE);
    load_out = (state == bwa_pkg::B_WRITE) && (!out_valid || out_ready);
  end

  // datapath
  always_comb begin
    rem_sh = {rem, 1'b0};
    rem_ge = (rem_sh >= {1'b0, divisor});

    ph  = pass ? {quo[30:0], 1'b0} : quo;
    // mirror the second and fourth quadrants
    r   = ph[30] ? (31'd1073741824 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
    idx = r[29:22];
    rom_a = ROM[{1'b0, idx}];
    rom_b = ROM[{1'b0, idx} + 9'd1];

    interp = diff_q * frac_q;
    mag    = down_q ? (a_q - delta_q) : (a_q + delta_q);
    c_new  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    case (wtype)
      bwa_pkg::WIN_HANN:     num = 38'sd25 * (38'sd1073741824 - 38'(c1));
      bwa_pkg::WIN_HAMMING:  num = 38'sd28991029248 - 38'sd23 * 38'(c1);
      bwa_pkg::WIN_BLACKMAN: num = 38'sd22548578304 - 38'sd25 * 38'(c1) + 38'sd4 * 38'(c2);
      default:               num = 38'sd53687091200;
    endcase
    num_r = (num < 0) ? '0 : num;

    scaled  = y_q * bwa_pkg::DIV25_MUL;
    rounded = (PRW + 1)'(prod_q) + (PRW + 1)'(65536);
    res     = rounded >>> 17;
  end

  always_ff @(posedge clk) begin
    case (state)
      bwa_pkg::B_IDLE: begin
        if (q_valid) begin
          {wtype, last, divisor} <= q_data[3+2*PW+SW-1:PW+SW];
          smp <= q_data[SW-1:0];
          // position equals divisor only at the block end: quotient wraps to zero
          rem <= (q_data[PW+SW-1:SW] == q_data[2*PW+SW-1:PW+SW]) ? '0 : q_data[PW+SW-1:SW];
          quo <= '0;
          div_cnt <= '0;
          pass <= 1'b0;
        end
      end
      bwa_pkg::B_DIV: begin
        if (divisor != '0) begin
          rem <= rem_ge ? PW'(rem_sh - {1'b0, divisor}) : PW'(rem_sh);
          quo <= {quo[30:0], rem_ge};
          div_cnt <= div_cnt + 1'b1;
        end
      end
      bwa_pkg::B_LOOK: begin
        neg_q  <= ph[31] ^ ph[30];
        frac_q <= {r[21:0], 8'd0};
        if (r[30]) begin
          a_q    <= ROM[bwa_pkg::COS_DEPTH];
          diff_q <= '0;
          down_q <= 1'b1;
        end else begin
          a_q    <= rom_a;
          diff_q <= (rom_a >= rom_b) ? rom_a - rom_b : rom_b - rom_a;
          down_q <= (rom_a >= rom_b);
        end
      end
      bwa_pkg::B_INTERP: delta_q <= interp[60:30];
      bwa_pkg::B_COMB: begin
        if (pass) begin
          c2 <= c_new;
        end else begin
          c1 <= c_new;
        end
        pass <= 1'b1;
      end
      bwa_pkg::B_NUM:   y_q <= 22'((num_r + 38'd204800) >> 14);
      bwa_pkg::B_SCALE: coef_q <= 18'(scaled >> bwa_pkg::DIV25_SHIFT);
      bwa_pkg::B_MUL:   prod_q <= PRW'(smp * $signed({1'b0, coef_q}));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bwa_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      last_in_block <= last;
      if (res > SMAX) begin
        windowed_sample <= SW'(SMAX);
      end else if (res < SMIN) begin
        windowed_sample <= SW'(SMIN);
      end else begin
        windowed_sample <= SW'(res);
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/block_window_applier.sv @@
// Each input beat is popped from the queue, its phase is formed by the bit-serial divider
// as a 32-bit quotient, the shared cosine unit makes two passes, then coefficient,
// product and output follow; a block of one skips the divider. The back part takes a new
// beat only once it is through with the last one, so the phase divider sets the pace.
// A two-entry queue lets the front take beats while the back
// works. Reset clears the position, both config registers (rectangular, MAX_BLOCK), valids.
`default_nettype none
module block_window_applier #(
  parameter int MAX_BLOCK    = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [bwa_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]          windowed_sample,
  output logic                                    last_in_block
);
  localparam int POS_WIDTH = $clog2(MAX_BLOCK);
  localparam int EW = 3 + 2 * POS_WIDTH + SAMPLE_WIDTH;

  logic          fq_valid;
  logic          fq_ready;
  logic [EW-1:0] fq_data;
  logic          qb_valid;
  logic          qb_ready;
  logic [EW-1:0] qb_data;

  bwa_front #(
    .MAX_BLOCK(MAX_BLOCK),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .q_valid(fq_valid),
    .q_ready(fq_ready),
    .q_data(fq_data)
  );

  bwa_queue #(
    .WIDTH(EW),
    .DEPTH(2)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_data(fq_data),
    .rd_valid(qb_valid),
    .rd_ready(qb_ready),
    .rd_data(qb_data)
  );

  bwa_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .POS_WIDTH(POS_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(qb_valid),
    .q_ready(qb_ready),
    .q_data(qb_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .windowed_sample(windowed_sample),
    .last_in_block(last_in_block)
  );
endmodule
`default_nettype wire
